// ----- rtl/fstseq_pkg.sv -----
// ----------------------------------------------------------------------------
// fstseq_pkg
// Shared types, constants and tables of the faded sine tone sequencer.
// ----------------------------------------------------------------------------
package fstseq_pkg;

    // Tone and table geometry
    localparam int BUCKET_LEN     = 512;
    localparam int FADE_LEN       = 24;
    localparam int SAMPLE_RATE    = 16000;
    localparam int SINE_ENTRIES   = 1024;
    localparam int MS_PER_SECOND  = 1000;
    localparam int SAMPLES_PER_MS = SAMPLE_RATE / MS_PER_SECOND;

    // Port widths
    localparam int OP_W   = 2;
    localparam int FREQ_W = 14;
    localparam int DUR_W  = 16;
    localparam int SID_W  = 2;
    localparam int SMPL_W = 16;
    localparam int AMP_W  = 15;
    localparam int MAG_W  = 15;

    // Derived widths
    localparam int PH_W   = $clog2(SAMPLE_RATE);
    localparam int CNT_W  = DUR_W + $clog2(SAMPLES_PER_MS);
    localparam int POS_W  = $clog2(BUCKET_LEN);
    localparam int BLEN_W = POS_W + 1;
    localparam int SUM_W  = BLEN_W + 1;
    localparam int W_W    = $clog2(FADE_LEN + 1);
    localparam int IDX_W  = $clog2(SINE_ENTRIES);
    localparam int SINE_HALF = SINE_ENTRIES / 2;
    localparam int SINE_QTR  = SINE_ENTRIES / 4;
    localparam int QTR_W  = $clog2(SINE_QTR);
    localparam int ENT_W  = 4;

    // Phase to table index: floor(phase * SINE_ENTRIES / SAMPLE_RATE) by reciprocal
    localparam int IDX_SHIFT = 2 * PH_W;
    localparam longint unsigned IDX_RECIP =
        ((64'(SINE_ENTRIES) << IDX_SHIFT) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam int RECIP_W = $clog2(IDX_RECIP + 1);

    // Fade scaling: divide by 32767 * 24 as /8, /3 (reciprocal), /32767 (shift-add)
    localparam int P1_W = MAG_W + AMP_W;
    localparam int P2_W = P1_W + W_W;
    localparam int Q_W  = 2 * MAG_W;
    localparam longint unsigned DIV3_RECIP = 64'h0000_0000_AAAA_AAAB;
    localparam int DIV3_SHIFT = 33;

    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(22890);

    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned ONE_Q30  = 64'd1073741824;
    localparam longint unsigned Q15_FULL = 64'd32767;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_TONE = 2'd1,
        OP_SEQ  = 2'd2
    } t_op;

    localparam logic [SID_W-1:0] SEQ_TWO_TONE = 2'd0;
    localparam logic [SID_W-1:0] SEQ_BOOT     = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX,
        ST_ROM,
        ST_MAG,
        ST_WT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic en_idx;
        logic en_rom;
        logic en_mag;
        logic en_wt;
        logic en_div;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic tick_go;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [FREQ_W-1:0] hz;
        logic [DUR_W-1:0]  ms;
    } t_entry;

    function automatic logic [ENT_W-1:0] seq_len(input logic sel);
        return sel ? ENT_W'(7) : ENT_W'(4);
    endfunction

    function automatic t_entry seq_entry(input logic sel, input logic [ENT_W-1:0] idx);
        t_entry e;
        e.hz = '0;
        e.ms = '0;
        if (sel) begin
            case (idx)
                4'd0:    begin e.hz = 14'd2218; e.ms = 16'd38; end
                4'd1:    begin e.hz = 14'd0;    e.ms = 16'd77; end
                4'd2:    begin e.hz = 14'd1319; e.ms = 16'd38; end
                4'd3:    begin e.hz = 14'd0;    e.ms = 16'd77; end
                4'd4:    begin e.hz = 14'd2218; e.ms = 16'd38; end
                4'd5:    begin e.hz = 14'd0;    e.ms = 16'd77; end
                4'd6:    begin e.hz = 14'd2637; e.ms = 16'd38; end
                default: begin e.hz = 14'd0;    e.ms = 16'd0;  end
            endcase
        end else begin
            case (idx)
                4'd0:    begin e.hz = 14'd2000; e.ms = 16'd100; end
                4'd1:    begin e.hz = 14'd0;    e.ms = 16'd50;  end
                4'd2:    begin e.hz = 14'd4000; e.ms = 16'd100; end
                4'd3:    begin e.hz = 14'd0;    e.ms = 16'd50;  end
                default: begin e.hz = 14'd0;    e.ms = 16'd0;   end
            endcase
        end
        return e;
    endfunction

    // Quarter-wave sine magnitude for folded index j (angle pi*j/SINE_HALF),
    // Taylor series to x^17 in Q30 with truncated terms, rounded half up to Q15.
    // Evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] sine_q15(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        x    = (PI_Q30 * 64'(2 * j)) / 64'(SINE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        v = (64'(sum) * Q15_FULL + (ONE_Q30 >> 1)) >> 30;
        return v[MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/fstseq_ctrl.sv -----
// ----------------------------------------------------------------------------
// fstseq_ctrl
// Sequencer that accepts requests and steps one sample through the datapath.
// ----------------------------------------------------------------------------
module fstseq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  fstseq_pkg::t_status i_status,
    output fstseq_pkg::t_cmd    o_cmd,
    output logic                o_in_stall
);
    import fstseq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.tick_go) begin
                    n_state = ST_IDX;
                end
            end
            ST_IDX: n_state = ST_ROM;
            ST_ROM: n_state = ST_MAG;
            ST_MAG: n_state = ST_WT;
            ST_WT:  n_state = ST_DIV;
            ST_DIV: n_state = ST_OUT;
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            ST_IDX: o_cmd.en_idx = 1'b1;
            ST_ROM: o_cmd.en_rom = 1'b1;
            ST_MAG: o_cmd.en_mag = 1'b1;
            ST_WT:  o_cmd.en_wt  = 1'b1;
            ST_DIV: o_cmd.en_div = 1'b1;
            ST_OUT: o_cmd.load_out = i_status.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ----- rtl/fstseq_dp.sv -----
// ----------------------------------------------------------------------------
// fstseq_dp
// Tone state, sine lookup, fade scaling and the output register.
// ----------------------------------------------------------------------------
module fstseq_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fstseq_pkg::t_cmd                 i_cmd,
    output fstseq_pkg::t_status              o_status,
    input  logic [fstseq_pkg::OP_W-1:0]      i_operation,
    input  logic [fstseq_pkg::FREQ_W-1:0]    i_frequency_hz,
    input  logic [fstseq_pkg::DUR_W-1:0]     i_duration_ms,
    input  logic [fstseq_pkg::SID_W-1:0]     i_sequence_id,
    input  logic                             i_cfg_wr,
    input  logic [fstseq_pkg::AMP_W-1:0]     i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [fstseq_pkg::SMPL_W-1:0] o_sample,
    output logic                             o_audible,
    output logic                             o_last
);
    import fstseq_pkg::*;

    // Tone state
    logic [PH_W-1:0]  r_phase,   n_phase;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_total,   n_total;
    logic [PH_W-1:0]  r_step,    n_step;
    logic             r_audible, n_audible;
    logic             r_busy,    n_busy;
    logic             r_in_seq,  n_in_seq;
    logic             r_seq_sel, n_seq_sel;
    logic [ENT_W-1:0] r_entry,   n_entry;
    logic [AMP_W-1:0] r_amp;

    // Per-sample working registers
    logic [PH_W-1:0]  r_ph_s;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_rem;
    logic             r_aud_s;
    logic             r_last_s;
    logic [IDX_W-1:0] r_idx;
    logic [W_W-1:0]   r_w;
    logic [MAG_W-1:0] r_smag;
    logic             r_sneg;
    logic [P1_W-1:0]  r_p1;
    logic [P2_W-1:0]  r_p2;
    logic [Q_W-1:0]   r_q24;

    // Output register
    logic                     r_out_valid;
    logic signed [SMPL_W-1:0] r_sample;
    logic                     r_aud_o;
    logic                     r_last_o;

    t_op              op;
    logic             take_tick;
    logic [CNT_W-1:0] count_inc;
    logic [PH_W:0]    phase_sum;
    logic [PH_W-1:0]  phase_nxt;
    logic             last_hit;
    logic [ENT_W-1:0] entry_inc;
    logic             more;
    t_entry           nxt_entry;
    t_entry           ld;
    logic             do_ld;
    logic             tick_last;

    assign op        = t_op'(i_operation);
    assign take_tick = i_cmd.take && (op == OP_TICK) && r_busy;
    assign count_inc = r_count + CNT_W'(1);
    assign phase_sum = (PH_W+1)'(r_phase) + (PH_W+1)'(r_step);
    assign phase_nxt = (phase_sum >= (PH_W+1)'(SAMPLE_RATE))
                     ? PH_W'(phase_sum - (PH_W+1)'(SAMPLE_RATE)) : PH_W'(phase_sum);
    assign last_hit  = count_inc >= r_total;
    assign entry_inc = r_entry + ENT_W'(1);
    assign more      = r_in_seq && (entry_inc < seq_len(r_seq_sel));
    assign nxt_entry = seq_entry(r_seq_sel, entry_inc);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_total   = r_total;
        n_step    = r_step;
        n_audible = r_audible;
        n_busy    = r_busy;
        n_in_seq  = r_in_seq;
        n_seq_sel = r_seq_sel;
        n_entry   = r_entry;
        do_ld     = 1'b0;
        tick_last = 1'b0;
        ld.hz     = i_frequency_hz;
        ld.ms     = i_duration_ms;
        if (i_cmd.take) begin
            case (op)
                OP_TONE: begin
                    n_in_seq = 1'b0;
                    do_ld    = 1'b1;
                end
                OP_SEQ: begin
                    if (i_sequence_id inside {SEQ_TWO_TONE, SEQ_BOOT}) begin
                        n_seq_sel = i_sequence_id[0];
                        n_in_seq  = 1'b1;
                        n_entry   = '0;
                        do_ld     = 1'b1;
                        ld        = seq_entry(i_sequence_id[0], '0);
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        n_phase = phase_nxt;
                        n_count = count_inc;
                        if (last_hit) begin
                            if (more) begin
                                n_entry = entry_inc;
                                do_ld   = 1'b1;
                                ld      = nxt_entry;
                                if (nxt_entry.ms == '0) begin
                                    tick_last = 1'b1;
                                end
                            end else begin
                                tick_last = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        // Begin a tone: reduce the step once, clear phase and position
        if (do_ld) begin
            n_step    = (ld.hz >= FREQ_W'(SAMPLE_RATE))
                      ? PH_W'(ld.hz - FREQ_W'(SAMPLE_RATE)) : PH_W'(ld.hz);
            n_audible = ld.hz != '0;
            n_total   = CNT_W'(ld.ms) * CNT_W'(SAMPLES_PER_MS);
            n_count   = '0;
            n_phase   = '0;
            n_busy    = ld.ms != '0;
        end else if (tick_last) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_step    <= '0;
            r_audible <= 1'b0;
            r_busy    <= 1'b0;
            r_in_seq  <= 1'b0;
            r_seq_sel <= 1'b0;
            r_entry   <= '0;
            r_amp     <= AMP_RESET;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_total   <= n_total;
            r_step    <= n_step;
            r_audible <= n_audible;
            r_busy    <= n_busy;
            r_in_seq  <= n_in_seq;
            r_seq_sel <= n_seq_sel;
            r_entry   <= n_entry;
            if (i_cfg_wr) begin
                r_amp <= i_cfg_data;
            end
        end
    end

    // Snapshot the sample's position before the state advances
    always_ff @(posedge i_clk) begin
        if (take_tick) begin
            r_ph_s   <= r_phase;
            r_pos    <= r_count[POS_W-1:0];
            r_rem    <= r_total - (r_count & ~CNT_W'(BUCKET_LEN - 1));
            r_aud_s  <= r_audible;
            r_last_s <= tick_last;
        end
    end

    // Table index and fade weight
    logic [PH_W+RECIP_W-1:0] idx_prod;
    logic [BLEN_W-1:0]       blen;
    logic [SUM_W-1:0]        fade_sum;
    logic [W_W-1:0]          w_nxt;

    assign idx_prod = (PH_W+RECIP_W)'(r_ph_s) * (PH_W+RECIP_W)'(IDX_RECIP);
    assign blen     = (r_rem < CNT_W'(BUCKET_LEN)) ? r_rem[BLEN_W-1:0] : BLEN_W'(BUCKET_LEN);
    assign fade_sum = SUM_W'(r_pos) + SUM_W'(FADE_LEN);

    always_comb begin
        if (r_pos < POS_W'(FADE_LEN)) begin
            w_nxt = W_W'(r_pos);
        end else if (fade_sum > SUM_W'(blen)) begin
            w_nxt = W_W'(blen - BLEN_W'(r_pos));
        end else begin
            w_nxt = W_W'(FADE_LEN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_idx) begin
            r_idx <= idx_prod[IDX_SHIFT +: IDX_W];
            r_w   <= w_nxt;
        end
    end

    // Quarter-wave table, folded lookup
    logic [MAG_W-1:0] rom [SINE_QTR];
    localparam logic [MAG_W-1:0] SINE_PEAK = sine_q15(SINE_QTR);

    for (genvar g = 0; g < SINE_QTR; g++) begin : g_rom
        assign rom[g] = sine_q15(g);
    end

    logic             fold_neg;
    logic [IDX_W:0]   fold_half;
    logic [IDX_W-1:0] fold_j;

    assign fold_neg  = r_idx > IDX_W'(SINE_HALF);
    assign fold_half = fold_neg ? ((IDX_W+1)'(SINE_ENTRIES) - (IDX_W+1)'(r_idx))
                                : (IDX_W+1)'(r_idx);
    assign fold_j    = (fold_half > (IDX_W+1)'(SINE_QTR))
                     ? IDX_W'((IDX_W+1)'(SINE_HALF) - fold_half) : IDX_W'(fold_half);

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_rom) begin
            r_smag <= (fold_j == IDX_W'(SINE_QTR)) ? SINE_PEAK : rom[fold_j[QTR_W-1:0]];
            r_sneg <= fold_neg;
        end
    end

    // Scale by amplitude, then by fade weight, then divide by 24
    logic [63:0] div3_prod;

    assign div3_prod = 64'(r_p2[P2_W-1:3]) * DIV3_RECIP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_mag) begin
            r_p1 <= P1_W'(r_smag) * P1_W'(r_amp);
        end
        if (i_cmd.en_wt) begin
            r_p2 <= P2_W'(r_p1) * P2_W'(r_w);
        end
        if (i_cmd.en_div) begin
            r_q24 <= div3_prod[DIV3_SHIFT +: Q_W];
        end
    end

    // Divide by 32767 with shift-add, apply sign, load output
    logic [Q_W:0]              q_sum;
    logic [MAG_W-1:0]          mag;
    logic signed [SMPL_W-1:0]  sample_nxt;

    assign q_sum = (Q_W+1)'(r_q24) + (Q_W+1)'(r_q24 >> MAG_W) + (Q_W+1)'(1);
    assign mag   = q_sum[MAG_W +: MAG_W];

    always_comb begin
        if (!r_aud_s) begin
            sample_nxt = '0;
        end else if (r_sneg) begin
            sample_nxt = -$signed(SMPL_W'(mag));
        end else begin
            sample_nxt = $signed(SMPL_W'(mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sample <= sample_nxt;
            r_aud_o  <= r_aud_s;
            r_last_o <= r_last_s;
        end
    end

    assign o_status.tick_go  = (op == OP_TICK) && r_busy;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_audible   = r_aud_o;
    assign o_last      = r_last_o;

    a_busy_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_count < r_total))
        else $error("busy tone has run past its length");

    a_entry_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_seq |-> (r_entry < seq_len(r_seq_sel)))
        else $error("sequence entry beyond sequence length");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_aud_o) |-> (r_sample == '0))
        else $error("silent entry produced a nonzero sample");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_aud_o) |->
            ((r_sample[SMPL_W-1] ? -r_sample : r_sample) <= $signed(SMPL_W'(r_amp))))
        else $error("sample magnitude exceeds amplitude");

endmodule

// ----- rtl/faded_sine_tone_sequencer.sv -----
// A tick taken while a tone is busy yields a sample once the output register is free.
// Requests stall until that tick's six-step datapath walk ends
// (index multiply, table fold, two scale multiplies, divide, output load).
// Start requests, idle ticks and ignored requests are taken while idle and give no result.
// Reset (synchronous, active low) leaves the block idle with amplitude 22890.
// ----------------------------------------------------------------------------
// faded_sine_tone_sequencer
// Sine tone generator with bucket fades and two stored tone sequences.
// ----------------------------------------------------------------------------
module faded_sine_tone_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [fstseq_pkg::OP_W-1:0]          i_operation,
    input  logic [fstseq_pkg::FREQ_W-1:0]        i_frequency_hz,
    input  logic [fstseq_pkg::DUR_W-1:0]         i_duration_ms,
    input  logic [fstseq_pkg::SID_W-1:0]         i_sequence_id,
    // Sample channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fstseq_pkg::SMPL_W-1:0] o_sample,
    output logic                                 o_audible,
    output logic                                 o_last,
    // Amplitude register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fstseq_pkg::AMP_W-1:0]         i_cfg_data
);
    import fstseq_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The user must write the amplitude only while idle; the block does not enforce this, ready is tied high
    assign o_cfg_ready = 1'b1;

    // Controller: accept requests, then walk one sample through the datapath,
    // holding in the output step until the output register is free.
    fstseq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: tone state, sine table, fade scaling and output register.
    fstseq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_operation    (i_operation),
        .i_frequency_hz (i_frequency_hz),
        .i_duration_ms  (i_duration_ms),
        .i_sequence_id  (i_sequence_id),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample       (o_sample),
        .o_audible      (o_audible),
        .o_last         (o_last)
    );

endmodule
